// ----- rtl/lfst_pkg.sv -----
`default_nettype none
package lfst_pkg;
   localparam int Features = 60;
   localparam int Users = 1024;
   localparam int Movies = 2048;
   localparam int FeatW = $clog2(Features);
   localparam int UserW = $clog2(Users);
   localparam int MovieW = $clog2(Movies);
   localparam int UfDepth = Features * Users;
   localparam int MfDepth = Features * Movies;
   localparam int UfAw = $clog2(UfDepth);
   localparam int MfAw = $clog2(MfDepth);
   localparam logic [31:0] FactorInit = 32'sd6554;
   localparam logic [23:0] LrReset = 24'd1678;

   typedef enum logic [1:0] {
      FUNC_LOAD_MOVIE = 2'd0,
      FUNC_LOAD_USER  = 2'd1,
      FUNC_TRAIN      = 2'd2,
      FUNC_PREDICT    = 2'd3
   } func_type;

   typedef enum logic {
      CSR_LEARNING_RATE   = 1'b0,
      CSR_CURRENT_FEATURE = 1'b1
   } csr_index_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/latent_factor_sgd_trainer_top.sv -----
`default_nettype none
// A load's result strobe follows in the cycle after it is accepted; predict and train step
// through features 0 to the current feature (clamped to Features-1) before the result.
// Throughput: loads one per cycle; predict/train hold busy until the result strobe.
// One shared 32x32 multiplier serves the dot product, the squared error, the step and both updates.
// Reset: synchronous, clears control; then a clearing pass over Features*Movies (122880)
// addresses sets all factors to 0.1 while busy is high. Results cannot be stalled.
module latent_factor_sgd_trainer_top
   import lfst_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_func,
   input  wire logic [9:0]         req_user,
   input  wire logic [10:0]        req_movie,
   input  wire logic [2:0]         req_rating,
   input  wire logic signed [31:0] req_load_value,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_prediction,
   output logic signed [31:0]      rsp_rating_error,
   output logic [31:0]             rsp_squared_error,
   input  wire logic               csr_write,
   input  wire logic               csr_index,
   input  wire logic [23:0]        csr_data
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_WAIT, ST_MUL, ST_ACC, ST_ERR, ST_SQ, ST_SQ2,
      ST_G, ST_G2, ST_UM, ST_UM2, ST_MU, ST_MU2
   } state_type;

   state_type state_ff;
   logic [MfAw-1:0] clr_ff;
   logic [23:0] lr_ff;
   logic [5:0] cf_ff;
   func_type func_ff;
   logic [UserW-1:0] user_ff;
   logic [MovieW-1:0] movie_ff;
   logic [2:0] rating_ff;
   logic [FeatW-1:0] f_ff, cf_sat_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] uf_ff, mf_ff, err_ff, g_ff, pred_ff, unew_ff;
   logic [31:0] sq_ff;
   logic valid_ff;

   logic signed [31:0] uf_mem [UfDepth];
   logic signed [31:0] mf_mem [MfDepth];
   logic signed [31:0] mb_mem [Movies];
   logic signed [31:0] ub_mem [Users];
   logic signed [31:0] uf_rd, mf_rd, mb_rd, ub_rd;
   logic uf_we, mf_we;
   logic [UfAw-1:0] uf_wa;
   logic [MfAw-1:0] mf_wa;
   logic signed [31:0] uf_wd, mf_wd;
   logic [UfAw-1:0] uf_ra;
   logic [MfAw-1:0] mf_ra;

   logic mul_en;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] product;

   lfst_mac u_mac (.clock, .mul_en, .a(mul_a), .b(mul_b), .product);

   assign uf_ra = UfAw'(f_ff * Users + user_ff);
   assign mf_ra = MfAw'(f_ff * Movies + movie_ff);

   always_ff @(posedge clock) begin
      uf_rd <= uf_mem[uf_ra];
      mf_rd <= mf_mem[mf_ra];
      mb_rd <= mb_mem[movie_ff];
      ub_rd <= ub_mem[user_ff];
      if (uf_we) begin
         uf_mem[uf_wa] <= uf_wd;
      end
      if (mf_we) begin
         mf_mem[mf_wa] <= mf_wd;
      end
      if (start && !busy && req_func == FUNC_LOAD_MOVIE) begin
         mb_mem[req_movie] <= req_load_value;
      end
      if (start && !busy && req_func == FUNC_LOAD_USER) begin
         ub_mem[req_user] <= req_load_value;
      end
   end

   logic signed [63:0] rnd16, rnd24, err_wide;
   assign rnd16 = (product + 64'sd32768) >>> 16;
   assign rnd24 = (product + 64'sd8388608) >>> 24;
   assign err_wide = $signed({45'd0, rating_ff, 16'd0}) - 64'(pred_ff);

   always_comb begin
      mul_en = 1'b1;
      mul_a = uf_rd;
      mul_b = mf_rd;
      uf_we = 1'b0;
      mf_we = 1'b0;
      uf_wa = UfAw'(cf_sat_ff * Users + user_ff);
      mf_wa = MfAw'(cf_sat_ff * Movies + movie_ff);
      uf_wd = unew_ff;
      mf_wd = sat32(64'(mf_ff) + rnd16);
      unique case (state_ff)
         ST_CLEAR: begin
            uf_we = (clr_ff < MfAw'(UfDepth));
            mf_we = 1'b1;
            uf_wa = UfAw'(clr_ff);
            mf_wa = clr_ff;
            uf_wd = FactorInit;
            mf_wd = FactorInit;
         end
         ST_SQ: begin
            mul_a = err_ff;
            mul_b = err_ff;
         end
         ST_G: begin
            mul_a = $signed({8'd0, lr_ff});
            mul_b = err_ff;
         end
         ST_UM: begin
            mul_a = g_ff;
            mul_b = mf_ff;
         end
         ST_MU: begin
            mul_a = g_ff;
            mul_b = uf_ff;
         end
         ST_MU2: begin
            uf_we = 1'b1;
            mf_we = 1'b1;
         end
         default: mul_en = (state_ff == ST_MUL);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         lr_ff <= LrReset;
         cf_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_LEARNING_RATE:   lr_ff <= csr_data;
               CSR_CURRENT_FEATURE: cf_ff <= csr_data[5:0];
            endcase
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == MfAw'(MfDepth - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  func_ff <= func_type'(req_func);
                  user_ff <= req_user;
                  movie_ff <= req_movie;
                  rating_ff <= req_rating;
                  f_ff <= '0;
                  cf_sat_ff <= (cf_ff >= 6'(Features)) ? FeatW'(Features - 1)
                                                       : FeatW'(cf_ff);
                  if (req_func == FUNC_LOAD_MOVIE || req_func == FUNC_LOAD_USER) begin
                     pred_ff <= '0;
                     err_ff <= '0;
                     sq_ff <= '0;
                     valid_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_RD;
                  end
               end
            end
            ST_RD: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (f_ff == '0) begin
                  acc_ff <= 64'(mb_rd) + 64'(ub_rd);
               end
               if (f_ff == cf_sat_ff) begin
                  uf_ff <= uf_rd;
                  mf_ff <= mf_rd;
               end
               state_ff <= ST_MUL;
            end
            ST_MUL: state_ff <= ST_ACC;
            ST_ACC: begin
               acc_ff <= acc_ff + rnd16;
               if (f_ff == cf_sat_ff) begin
                  state_ff <= ST_ERR;
               end else begin
                  f_ff <= f_ff + 1'b1;
                  state_ff <= ST_RD;
               end
            end
            ST_ERR: begin
               pred_ff <= sat32(acc_ff);
               state_ff <= ST_SQ2;
            end
            ST_SQ2: begin
               err_ff <= sat32(err_wide);
               state_ff <= ST_SQ;
            end
            ST_SQ: state_ff <= ST_G;
            ST_G: begin
               sq_ff <= (rnd16 > 64'sh00000000FFFFFFFF) ? 32'hFFFFFFFF : rnd16[31:0];
               if (func_ff == FUNC_TRAIN) begin
                  state_ff <= ST_G2;
               end else begin
                  valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_G2: begin
               g_ff <= rnd24[31:0];
               state_ff <= ST_UM;
            end
            ST_UM: state_ff <= ST_UM2;
            ST_UM2: begin
               unew_ff <= sat32(64'(uf_ff) + rnd16);
               state_ff <= ST_MU;
            end
            ST_MU: state_ff <= ST_MU2;
            ST_MU2: begin
               valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_prediction = pred_ff;
   assign rsp_rating_error = err_ff;
   assign rsp_squared_error = sq_ff;

`ifndef SYNTHESIS
   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == FUNC_LOAD_MOVIE || req_func == FUNC_LOAD_USER))
      |=> rsp_valid) else $error("load result missing");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
`endif
endmodule
`default_nettype wire

// ----- rtl/lfst_mac.sv -----
`default_nettype none
module lfst_mac
   import lfst_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               mul_en,
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   output logic signed [63:0]      product
);
   logic signed [63:0] product_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= a * b;
      end
   end

   assign product = product_ff;
endmodule
`default_nettype wire
